// ===== hdl/stip_pkg.sv =====
// ----------------------------------------------------------------------------
// stip_pkg : shared types and constants of the string to integer parser
// Phase encoding, character codes and the digit decode.
// ----------------------------------------------------------------------------
package stip_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEAD   = 3'd1,
    PH_SIGNED = 3'd2,
    PH_ZERO   = 3'd3,
    PH_DIGITS = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  localparam logic [5:0] BASE_MAX   = 6'd36;
  localparam logic [5:0] BASE_OCT   = 6'd8;
  localparam logic [5:0] BASE_DEC   = 6'd10;
  localparam logic [5:0] BASE_HEX   = 6'd16;
  localparam logic [5:0] BASE_AUTO  = 6'd0;
  localparam logic [5:0] BASE_ONE   = 6'd1;
  localparam logic [5:0] DIGIT_NONE = 6'd36;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] LO_BIAS  = 8'd87;  // 'a' - 10
  localparam logic [7:0] UP_BIAS  = 8'd55;  // 'A' - 10

  // digit value 0..35, DIGIT_NONE for anything else
  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'(DIGIT_NONE);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = c - LO_BIAS;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = c - UP_BIAS;
    end
    return d[5:0];
  endfunction

endpackage

// ===== hdl/string_to_integer_parser_core.sv =====
// ----------------------------------------------------------------------------
// string_to_integer_parser_core : streaming strtol, bases 2 to 36 or auto (0)
// Takes one character a word, returns one parsed value per string.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall   | in_ch[7:0], in_first
//  out     | output    | out_valid / out_stall | out_value, out_end_offset,
//          |           |                       | out_range_error, out_base_error
//  cfg     | input     | cfg_wr_en             | cfg_wr_data[5:0] (radix)
//
//  One character per cycle. Each word updates the parse state in the cycle it
//  is accepted; the multiply-accumulate and limit compare of the digit loop
//  sit in that one cycle. A result word shows on out_* the cycle after the
//  terminating character. rst_n is synchronous, active low, and clears the
//  phase, radix and output valid. in_stall is high only while a result word
//  is held and stalled; the output register frees the input side otherwise.
// ----------------------------------------------------------------------------
module string_to_integer_parser_core #(
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [5:0]                   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_ch,
  input  logic                         in_first,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [VALUE_BITS-1:0] out_value,
  output logic [COUNT_BITS-1:0]        out_end_offset,
  output logic                         out_range_error,
  output logic                         out_base_error
);

  // product width: magnitude times a 6-bit base plus a digit
  localparam int PW = VALUE_BITS + 7;
  localparam logic [VALUE_BITS-1:0] NEG_LIMIT = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] POS_LIMIT = {1'b0, {(VALUE_BITS-1){1'b1}}};

  // parse state
  stip_pkg::phase_t        phase_r, phase_nxt;
  logic [5:0]              radix_r;
  logic                    neg_r, neg_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [VALUE_BITS-1:0]   acc_r, acc_nxt;
  logic [5:0]              base_r, base_nxt;
  logic [COUNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                    seen_r, seen_nxt;

  // result register
  logic                    out_valid_r;
  logic [VALUE_BITS-1:0]   value_r, value_nxt;
  logic [COUNT_BITS-1:0]   offset_r, offset_nxt;
  logic                    range_r, range_nxt;
  logic                    berr_r, berr_nxt;

  logic                    accept;
  logic                    emit;
  logic                    do_start;
  logic                    do_digit;
  logic                    bump;
  logic [5:0]              dig;
  logic [VALUE_BITS-1:0]   limit;
  logic [PW-1:0]           prod;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    ovf_nxt    = ovf_r;
    acc_nxt    = acc_r;
    base_nxt   = base_r;
    cnt_nxt    = cnt_r;
    seen_nxt   = seen_r;
    emit       = 1'b0;
    berr_nxt   = 1'b0;
    do_start   = 1'b0;
    do_digit   = 1'b0;
    bump       = 1'b0;
    dig        = stip_pkg::digit_of(in_ch);
    limit      = POS_LIMIT;
    prod       = '0;

    // new string: fresh state, radix sampled here
    if (in_first) begin
      neg_nxt  = 1'b0;
      ovf_nxt  = 1'b0;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      seen_nxt = 1'b0;
      base_nxt = radix_r;
      if (radix_r == stip_pkg::BASE_ONE || radix_r > stip_pkg::BASE_MAX) begin
        emit      = 1'b1;
        berr_nxt  = 1'b1;
        phase_nxt = stip_pkg::PH_DONE;
      end else begin
        phase_nxt = stip_pkg::PH_LEAD;
      end
    end

    if (!emit) begin
      case (phase_nxt)
        stip_pkg::PH_LEAD: begin
          if (in_ch inside {[stip_pkg::CH_TAB:stip_pkg::CH_CR], stip_pkg::CH_SPACE}) begin
            bump = 1'b1;
          end else if (in_ch == stip_pkg::CH_PLUS || in_ch == stip_pkg::CH_MINUS) begin
            neg_nxt   = (in_ch == stip_pkg::CH_MINUS);
            bump      = 1'b1;
            phase_nxt = stip_pkg::PH_SIGNED;
          end else begin
            do_start = 1'b1;
          end
        end
        stip_pkg::PH_SIGNED: begin
          do_start = 1'b1;
        end
        stip_pkg::PH_ZERO: begin
          // 0x prefix: drop the zero, switch to hex
          if (in_ch == stip_pkg::CH_LO_X || in_ch == stip_pkg::CH_UP_X) begin
            base_nxt  = stip_pkg::BASE_HEX;
            seen_nxt  = 1'b0;
            bump      = 1'b1;
            phase_nxt = stip_pkg::PH_DIGITS;
          end else begin
            do_digit = 1'b1;
          end
        end
        stip_pkg::PH_DIGITS: begin
          do_digit = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // leading zero may open a prefix in auto or hex base
    if (do_start) begin
      if (in_ch == stip_pkg::CH_ZERO &&
          (base_nxt == stip_pkg::BASE_AUTO || base_nxt == stip_pkg::BASE_HEX)) begin
        if (base_nxt == stip_pkg::BASE_AUTO) begin
          base_nxt = stip_pkg::BASE_OCT;
        end
        acc_nxt   = '0;
        seen_nxt  = 1'b1;
        bump      = 1'b1;
        phase_nxt = stip_pkg::PH_ZERO;
      end else begin
        if (base_nxt == stip_pkg::BASE_AUTO) begin
          base_nxt = stip_pkg::BASE_DEC;
        end
        do_digit = 1'b1;
      end
    end

    if (do_digit) begin
      if (base_nxt < 6'd2 || dig >= base_nxt) begin
        emit      = 1'b1;
        phase_nxt = stip_pkg::PH_DONE;
      end else begin
        // acc*base + d > limit is the overflow test
        limit = neg_nxt ? NEG_LIMIT : POS_LIMIT;
        prod  = PW'(acc_nxt) * PW'(base_nxt) + PW'(dig);
        if (!ovf_nxt) begin
          if (prod > PW'(limit)) begin
            acc_nxt = limit;
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = prod[VALUE_BITS-1:0];
          end
        end
        seen_nxt  = 1'b1;
        bump      = 1'b1;
        phase_nxt = stip_pkg::PH_DIGITS;
      end
    end

    // offset counter sticks at all ones
    if (bump && cnt_nxt != '1) begin
      cnt_nxt = cnt_nxt + 1'b1;
    end

    // result word, from state before the terminator
    value_nxt  = '0;
    offset_nxt = '0;
    range_nxt  = 1'b0;
    if (!berr_nxt && seen_nxt) begin
      value_nxt  = neg_nxt ? ('0 - acc_nxt) : acc_nxt;
      offset_nxt = cnt_nxt;
    end
    if (!berr_nxt) begin
      range_nxt = ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= stip_pkg::PH_IDLE;
      radix_r     <= '0;
      neg_r       <= 1'b0;
      ovf_r       <= 1'b0;
      acc_r       <= '0;
      base_r      <= '0;
      cnt_r       <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        radix_r <= cfg_wr_data;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        ovf_r   <= ovf_nxt;
        acc_r   <= acc_nxt;
        base_r  <= base_nxt;
        cnt_r   <= cnt_nxt;
        seen_r  <= seen_nxt;
      end
      if (accept && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      value_r  <= value_nxt;
      offset_r <= offset_nxt;
      range_r  <= range_nxt;
      berr_r   <= berr_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = value_r;
  assign out_end_offset  = offset_r;
  assign out_range_error = range_r;
  assign out_base_error  = berr_r;

endmodule

// ===== hdl/stip_checker.sv =====
// ----------------------------------------------------------------------------
// stip_checker : port-level checks for the string to integer parser
// Watches the top-level ports; bound onto every instance of the core.
// ----------------------------------------------------------------------------
module stip_checker #(
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [VALUE_BITS-1:0] out_value,
  input logic [COUNT_BITS-1:0]        out_end_offset,
  input logic                         out_range_error,
  input logic                         out_base_error
);

  localparam logic [VALUE_BITS-1:0] V_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] V_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) &&
    $stable(out_end_offset) && $stable(out_range_error) && $stable(out_base_error))
    else $error("stalled result word changed");

  // input side only backs up behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // bad base reports nothing else
  a_base_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_base_error |->
    out_value == '0 && out_end_offset == '0 && !out_range_error)
    else $error("base error with payload");

  // no digits: zero value, no range flag
  a_no_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_offset == '0 |-> out_value == '0 && !out_range_error)
    else $error("no-digit result not clean");

  // saturation lands on a limit
  a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |->
    out_value == V_MIN || out_value == V_MAX)
    else $error("range error without saturated value");

endmodule

bind string_to_integer_parser_core stip_checker #(
  .VALUE_BITS(VALUE_BITS),
  .COUNT_BITS(COUNT_BITS)
) u_stip_checker (.*);
